>>> sv/edf_unit_time_scheduler_macros.svh
// Assertion macros for the EDF scheduler.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef EDF_UNIT_TIME_SCHEDULER_MACROS_SVH
`define EDF_UNIT_TIME_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define EDFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define EDFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/edfs_pkg.sv
// Shared types and constants for the EDF scheduler.
// No dependencies; imported by edfs_cell, edf_unit_time_scheduler and tb_top.
package edfs_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W = 4;
    localparam int VAL_W  = 16;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 5;
    localparam int RUN_W  = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [SLOT_W-1:0]  slot;
        logic [VAL_W-1:0]   arrival_time;
        logic [VAL_W-1:0]   burst_length;
        logic [VAL_W-1:0]   due_time;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  tick_time;
        logic               busy_res;
        logic [RUN_W-1:0]   run_id;
        logic               finished;
        logic [TIME_W-1:0]  finish_time;
        logic [TIME_W-1:0]  turnaround;
        logic [TIME_W-1:0]  waiting;
        logic               all_done;
    } out_item_t;

    // Running best candidate, handed from cell to cell during a scan.
    typedef struct packed {
        logic               found;
        logic [VAL_W-1:0]   best_dl;
        logic [IDX_W-1:0]   pick;
        logic [VAL_W-1:0]   arrival;
        logic [VAL_W-1:0]   burst;
        logic               rem_one;
        logic [1:0]         nz_cnt;   // slots in use with work left, saturates at 2
    } token_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic               load_en;
        logic [SLOT_W-1:0]  load_slot;
        logic [VAL_W-1:0]   load_arr;
        logic [VAL_W-1:0]   load_burst;
        logic [VAL_W-1:0]   load_dl;
        logic               dec_en;
        logic [IDX_W-1:0]   dec_slot;
        logic [TIME_W-1:0]  now;
        logic [CNT_W-1:0]   proc_count;
    } cell_ctrl_t;

endpackage

>>> sv/edfs_cell.sv
// One process slot of the EDF scheduler chain: holds the slot's stores and
// folds itself into the candidate token passed from its neighbor.
// Depends on edfs_pkg.
module edfs_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [edfs_pkg::IDX_W-1:0]  cell_idx,
    input  edfs_pkg::cell_ctrl_t        ctrl,
    input  edfs_pkg::token_t            tok_in,
    output edfs_pkg::token_t            tok_out
);
    import edfs_pkg::*;

    logic [VAL_W-1:0] arr_reg;
    logic [VAL_W-1:0] burst_reg;
    logic [VAL_W-1:0] dl_reg;
    logic [VAL_W-1:0] rem_reg;
    token_t           tok_reg;
    token_t           tok_next;

    logic hit_load;
    logic hit_dec;
    logic in_use;
    logic has_work;
    logic eligible;
    logic take;

    assign hit_load = ctrl.load_en && (32'(ctrl.load_slot) == 32'(cell_idx));
    assign hit_dec  = ctrl.dec_en && (ctrl.dec_slot == cell_idx);
    assign in_use   = 32'(cell_idx) < 32'(ctrl.proc_count);
    assign has_work = (rem_reg != '0);
    assign eligible = in_use && has_work && (TIME_W'(arr_reg) <= ctrl.now);
    // strict less-than keeps the lower slot on equal deadlines
    assign take     = eligible && (!tok_in.found || (dl_reg < tok_in.best_dl));

    always_comb begin
        tok_next = tok_in;
        if (take) begin
            tok_next.found   = 1'b1;
            tok_next.best_dl = dl_reg;
            tok_next.pick    = cell_idx;
            tok_next.arrival = arr_reg;
            tok_next.burst   = burst_reg;
            tok_next.rem_one = (rem_reg == VAL_W'(1));
        end
        if (in_use && has_work && (tok_in.nz_cnt != 2'd2)) begin
            tok_next.nz_cnt = tok_in.nz_cnt + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
        if (hit_load) begin
            arr_reg   <= ctrl.load_arr;
            burst_reg <= ctrl.load_burst;
            dl_reg    <= ctrl.load_dl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (hit_load) begin
            rem_reg <= ctrl.load_burst;
        end else if (hit_dec) begin
            rem_reg <= rem_reg - VAL_W'(1);
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> sv/edf_unit_time_scheduler.sv
// Preemptive earliest-deadline-first scheduler, one unit of time per tick
// transaction. A load transaction produces no result. A tick transaction goes
// from acceptance to a valid result as follows: the candidate token walks
// the row of slot cells one cell per cycle, then the CALC state updates the
// picked slot and time, and the FINISH state forms the waiting time.
// The next transaction is accepted once the result is taken.
// process_count may only be written while no tick is in flight.
// Depends on edfs_pkg, edfs_cell and edf_unit_time_scheduler_macros.svh.
`include "edf_unit_time_scheduler_macros.svh"

module edf_unit_time_scheduler (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  edfs_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output edfs_pkg::out_item_t         m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [edfs_pkg::CNT_W-1:0]  cfg_data
);
    import edfs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_FINISH,
        ST_OUT
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [CNT_W-1:0]   pc_reg;
    logic               m_valid_reg;
    out_item_t          out_reg;
    logic [TIME_W-1:0]  ta_reg;
    logic [VAL_W-1:0]   bu_reg;

    cell_ctrl_t         ctrl;
    token_t             tok [SLOTS];
    token_t             result_tok;
    logic [TIME_W-1:0]  fin_calc;
    logic               s_fire;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign result_tok = tok[SLOTS-1];
    assign fin_calc   = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + TIME_W'(1);

    always_comb begin
        ctrl            = '0;
        ctrl.load_en    = s_fire && (s_data.action == ACT_LOAD);
        ctrl.load_slot  = s_data.slot;
        ctrl.load_arr   = s_data.arrival_time;
        ctrl.load_burst = s_data.burst_length;
        ctrl.load_dl    = s_data.due_time;
        ctrl.dec_en     = (state_reg == ST_CALC) && result_tok.found;
        ctrl.dec_slot   = result_tok.pick;
        ctrl.now        = time_reg;
        ctrl.proc_count = pc_reg;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        token_t tok_in_w;
        if (g == 0) begin : g_head
            assign tok_in_w = '0;
        end else begin : g_link
            assign tok_in_w = tok[g-1];
        end
        edfs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(g)),
            .ctrl     (ctrl),
            .tok_in   (tok_in_w),
            .tok_out  (tok[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            time_reg     <= '0;
            pc_reg       <= CNT_W'(1);
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                pc_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    scan_cnt_reg <= '0;
                    if (s_fire && (s_data.action == ACT_TICK)) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                    if (scan_cnt_reg == IDX_W'(SLOTS - 1)) begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    out_reg.tick_time   <= time_reg;
                    out_reg.busy_res    <= result_tok.found;
                    out_reg.run_id      <= result_tok.found ?
                                           RUN_W'(result_tok.pick) + RUN_W'(1) : '0;
                    out_reg.finished    <= result_tok.found && result_tok.rem_one;
                    out_reg.finish_time <= fin_calc;
                    // only the picked slot can be the single busy one
                    out_reg.all_done    <= (result_tok.nz_cnt == 2'd0) ||
                                           ((result_tok.nz_cnt == 2'd1) &&
                                            result_tok.found && result_tok.rem_one);
                    ta_reg              <= fin_calc - TIME_W'(result_tok.arrival);
                    bu_reg              <= result_tok.burst;
                    if (time_reg != TIME_MAX) begin
                        time_reg <= time_reg + TIME_W'(1);
                    end
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_reg.finished) begin
                        out_reg.turnaround <= ta_reg;
                        out_reg.waiting    <= (ta_reg >= TIME_W'(bu_reg)) ?
                                              ta_reg - TIME_W'(bu_reg) : '0;
                    end else begin
                        out_reg.finish_time <= '0;
                        out_reg.turnaround  <= '0;
                        out_reg.waiting     <= '0;
                    end
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `EDFS_ASSERT_NOW(a_idle_no_result, s_ready, !m_valid, "result pending while accepting input")
    `EDFS_ASSERT_NEXT(a_tick_starts_scan, s_valid && s_ready && (s_data.action == ACT_TICK), !s_ready && !m_valid, "tick did not start a scan")
    `EDFS_ASSERT_NOW(a_finish_needs_run, m_valid && (m_data.finished || (m_data.run_id != '0)), m_data.busy_res, "finish or run id without a running slot")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for edf_unit_time_scheduler: directed table, then random phases.
// Needs edfs_pkg and the scheduler RTL. Results are checked against an EDF predictor.
module tb_top;
    import edfs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 30;

    typedef enum logic {
        ROW_CFG,
        ROW_XACT
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CNT_W-1:0]  count;
        in_item_t          item;
        bit                pinned;
        out_item_t         want;
    } dir_row_t;

    typedef struct {
        bit         pinned;
        out_item_t  want;
    } pin_tag_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   cfg_data = '0;

    // scheduler state as the bench sees it
    logic [VAL_W-1:0]   p_arrival [SLOTS];
    logic [VAL_W-1:0]   p_burst [SLOTS];
    logic [VAL_W-1:0]   p_deadline [SLOTS];
    logic [VAL_W-1:0]   p_left [SLOTS];
    logic [TIME_W-1:0]  p_now = '0;
    logic [CNT_W-1:0]   p_count = 5'd1;

    out_item_t          tick_reports_q [$];
    pin_tag_t           pin_q [$];
    dir_row_t           dir_rows [$];

    int                 fail_cnt = 0;
    int                 cyc = 0;
    int                 sent = 0;
    int                 burst_left = 0;
    int                 rx_mode = 0;
    int                 rx_hold = 0;

    edf_unit_time_scheduler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        for (int k = 0; k < SLOTS; k++) begin
            p_arrival[k]  = '0;
            p_burst[k]    = '0;
            p_deadline[k] = '0;
            p_left[k]     = '0;
        end
    end

    // One scheduler step; returns 1 when the transaction produces a tick report.
    function automatic bit edf_step(input in_item_t it, output out_item_t r);
        int unsigned        n;
        bit                 found;
        int unsigned        pick;
        logic [VAL_W-1:0]   best;
        logic [TIME_W-1:0]  fin;
        logic [TIME_W-1:0]  ta;
        r = '0;
        found = 1'b0;
        pick = 0;
        best = '0;
        if (it.action == ACT_LOAD) begin
            p_arrival[it.slot]  = it.arrival_time;
            p_burst[it.slot]    = it.burst_length;
            p_deadline[it.slot] = it.due_time;
            p_left[it.slot]     = it.burst_length;
            return 1'b0;
        end
        n = (p_count > SLOTS) ? SLOTS : p_count;
        for (int k = 0; k < n; k++) begin
            if (TIME_W'(p_arrival[k]) <= p_now && p_left[k] != 0) begin
                if (!found || p_deadline[k] < best) begin
                    found = 1'b1;
                    best = p_deadline[k];
                    pick = k;
                end
            end
        end
        r.tick_time = p_now;
        if (found) begin
            r.busy_res = 1'b1;
            r.run_id = RUN_W'(pick + 1);
            p_left[pick] = p_left[pick] - 1'b1;
            if (p_left[pick] == 0) begin
                fin = (p_now == TIME_MAX) ? TIME_MAX : p_now + 1;
                ta = fin - TIME_W'(p_arrival[pick]);
                r.finished = 1'b1;
                r.finish_time = fin;
                r.turnaround = ta;
                r.waiting = (ta >= TIME_W'(p_burst[pick])) ? ta - TIME_W'(p_burst[pick]) : '0;
            end
        end
        if (p_now != TIME_MAX)
            p_now = p_now + 1;
        r.all_done = 1'b1;
        for (int k = 0; k < n; k++) begin
            if (p_left[k] != 0)
                r.all_done = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic in_item_t load_item(input logic [SLOT_W-1:0] slot,
                                           input logic [VAL_W-1:0] arr,
                                           input logic [VAL_W-1:0] bur,
                                           input logic [VAL_W-1:0] dl);
        in_item_t it;
        it.action = ACT_LOAD;
        it.slot = slot;
        it.arrival_time = arr;
        it.burst_length = bur;
        it.due_time = dl;
        return it;
    endfunction

    // tick payload fields are don't-care, so fill them with noise
    function automatic in_item_t rand_tick();
        in_item_t it;
        it.action = ACT_TICK;
        it.slot = SLOT_W'($urandom);
        it.arrival_time = VAL_W'($urandom);
        it.burst_length = VAL_W'($urandom);
        it.due_time = VAL_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t rand_load(input logic [SLOT_W-1:0] slot);
        logic [VAL_W-1:0] arr;
        logic [VAL_W-1:0] bur;
        logic [VAL_W-1:0] dl;
        case ($urandom_range(0, 15))
            0:       arr = VAL_W'($urandom);
            1:       arr = '0;
            default: arr = VAL_W'(p_now) + VAL_W'($urandom_range(0, 8));
        endcase
        case ($urandom_range(0, 31))
            0:       bur = '0;
            1:       bur = VAL_W'($urandom);
            default: bur = VAL_W'($urandom_range(1, 6));
        endcase
        dl = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, 3)) : VAL_W'($urandom);
        return load_item(slot, arr, bur, dl);
    endfunction

    function automatic out_item_t idle_report(input logic [TIME_W-1:0] t);
        out_item_t r;
        r = '0;
        r.tick_time = t;
        r.all_done = 1'b1;
        return r;
    endfunction

    function automatic void add_cfg(input logic [CNT_W-1:0] n);
        dir_row_t row;
        row = '{ROW_CFG, n, '0, 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_xact(input in_item_t it, input bit pinned, input out_item_t want);
        dir_row_t row;
        row = '{ROW_XACT, '0, it, pinned, want};
        dir_rows.push_back(row);
    endfunction

    task automatic push_item(input in_item_t it, input bit pinned, input out_item_t want);
        pin_tag_t tag;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        tag.pinned = pinned;
        tag.want = want;
        pin_q.push_back(tag);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        sent++;
    endtask

    // loads give no report, so hold off a full tick latency after the queue drains
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (tick_reports_q.size() != 0 || pin_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] n);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // receiver: picks a random mode, each with its own stall shape
    always @(posedge aclk) begin
        if (cyc % 300 == 0)
            rx_mode = $urandom_range(0, 3);
        if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            case (rx_mode)
                0: begin
                    m_ready <= 1'b1;
                    rx_hold = 15;
                end
                1: begin
                    m_ready <= ~m_ready;
                    rx_hold = $urandom_range(0, 2);
                end
                2: m_ready <= ($urandom_range(0, 1) == 1);
                default: begin
                    m_ready <= ~m_ready;
                    rx_hold = m_ready ? $urandom_range(4, 12) : $urandom_range(0, 2);
                end
            endcase
        end
    end

    always @(posedge aclk) begin : monitor
        pin_tag_t   tag;
        out_item_t  r;
        out_item_t  want;
        bit         bad;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                p_count = cfg_data;
            if (s_valid && s_ready) begin
                tag = pin_q.pop_front();
                if (edf_step(s_data, r))
                    tick_reports_q.push_back(tag.pinned ? tag.want : r);
            end
            if (m_valid && m_ready) begin
                if (tick_reports_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("unexpected tick report at cycle %0d: %p", cyc, m_data);
                    fail_cnt++;
                end else begin
                    want = tick_reports_q.pop_front();
                    bad = (m_data.tick_time   !== want.tick_time)   ||
                          (m_data.busy_res    !== want.busy_res)    ||
                          (m_data.run_id      !== want.run_id)      ||
                          (m_data.finished    !== want.finished)    ||
                          (m_data.finish_time !== want.finish_time) ||
                          (m_data.turnaround  !== want.turnaround)  ||
                          (m_data.waiting     !== want.waiting)     ||
                          (m_data.all_done    !== want.all_done);
                    if (bad) begin
                        if (fail_cnt < 10)
                            $display("mismatch at cycle %0d\n  expected %p\n  actual   %p",
                                     cyc, want, m_data);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : driver
        int                 n_use;
        int                 ticks;
        int                 order [SLOTS];
        int                 j;
        int                 tmp;
        logic [CNT_W-1:0]   cnt;
        in_item_t           it;
        out_item_t          none;
        none = '0;

        // directed table; reset count is 1 and time starts at 0
        add_xact(rand_tick(), 1'b1, idle_report(0));           // slot 0 never loaded
        add_cfg(5'd0);
        add_xact(rand_tick(), 1'b1, idle_report(1));           // no slot in use
        add_cfg(5'd31);                                        // clamps to all slots
        add_xact(rand_tick(), 1'b1, idle_report(2));
        add_xact(load_item(4'd15, 16'd0, 16'd1, 16'hFFFF), 1'b0, none);
        add_xact(load_item(4'd0, 16'd0, 16'd2, 16'hFFFF), 1'b0, none);   // deadline tie
        add_xact(load_item(4'd3, 16'hFFFF, 16'hFFFF, 16'd0), 1'b0, none);
        add_xact(load_item(4'd7, 16'd0, 16'd0, 16'd0), 1'b0, none);      // zero burst
        add_xact(rand_tick(), 1'b0, none);
        add_xact(rand_tick(), 1'b0, none);
        add_xact(load_item(4'd5, 16'd4, 16'd3, 16'd100), 1'b0, none);
        add_xact(rand_tick(), 1'b0, none);
        add_xact(load_item(4'd5, 16'd0, 16'd1, 16'hFFFE), 1'b0, none);   // reload mid-run
        add_xact(rand_tick(), 1'b0, none);
        add_xact(rand_tick(), 1'b0, none);
        add_xact(rand_tick(), 1'b0, none);
        add_cfg(5'd16);
        add_xact(load_item(4'd3, 16'd0, 16'd1, 16'hA5A5), 1'b0, none);
        add_xact(rand_tick(), 1'b0, none);
        add_cfg(5'd1);
        add_xact(rand_tick(), 1'b1, idle_report(10));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                wait_idle();
                write_count(dir_rows[k].count);
            end else begin
                push_item(dir_rows[k].item, dir_rows[k].pinned, dir_rows[k].want);
            end
        end

        // random phases: set count, load the slots in use, then run ticks
        while (sent < TARGET_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 15))
                0:       cnt = 5'd0;
                1:       cnt = 5'd1;
                2:       cnt = 5'd16;
                3:       cnt = CNT_W'($urandom_range(17, 31));
                default: cnt = CNT_W'($urandom_range(2, 15));
            endcase
            write_count(cnt);
            n_use = (cnt > SLOTS) ? SLOTS : cnt;
            for (int k = 0; k < SLOTS; k++)
                order[k] = k;
            for (int k = n_use - 1; k > 0; k--) begin
                j = $urandom_range(0, k);
                tmp = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            ticks = $urandom_range(0, 6);
            if (n_use == 0) begin
                repeat (2) push_item(rand_load(SLOT_W'($urandom)), 1'b0, none);
            end
            for (int k = 0; k < n_use; k++) begin
                it = rand_load(SLOT_W'(order[k]));
                if (it.burst_length <= 6)
                    ticks += it.burst_length;
                push_item(it, 1'b0, none);
            end
            if (ticks > 60)
                ticks = 60;
            for (int k = 0; k < ticks; k++) begin
                if ($urandom_range(0, 15) == 0)
                    push_item(rand_load(SLOT_W'($urandom)), 1'b0, none);
                push_item(rand_tick(), 1'b0, none);
            end
        end

        wait_idle();
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
